// ===== rtl/core/jsu_pkg.sv =====
// ============================================================================
// jsu_pkg - shared types and constants for the JSON string unescaper
// Status codes, character codes and the UTF-8 encoder used by the decode
// stage.
// ============================================================================
package jsu_pkg;

  // Status codes carried with every result
  localparam logic [2:0] ST_RUN  = 3'd0;
  localparam logic [2:0] ST_OK   = 3'd1;
  localparam logic [2:0] ST_NOQ  = 3'd2;
  localparam logic [2:0] ST_ESC  = 3'd3;
  localparam logic [2:0] ST_HEX  = 3'd4;
  localparam logic [2:0] ST_SURR = 3'd5;
  localparam logic [2:0] ST_CTRL = 3'd6;
  localparam logic [2:0] ST_OPEN = 3'd7;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Surrogate ranges
  localparam logic [15:0] HI_SURR_LO = 16'hD800;
  localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
  localparam logic [15:0] LO_SURR_LO = 16'hDC00;
  localparam logic [15:0] LO_SURR_HI = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // Result burst: up to four bytes, lowest slot goes out first
  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
  } burst_t;

  // Encode a code point as 1 to 4 UTF-8 bytes
  function automatic burst_t utf8_encode(input logic [20:0] u);
    burst_t b;
    b.bytes = '0;
    if (u <= 21'h7F) begin
      b.cnt      = 3'd1;
      b.bytes[0] = u[7:0];
    end else if (u <= 21'h7FF) begin
      b.cnt      = 3'd2;
      b.bytes[0] = {3'b110, u[10:6]};
      b.bytes[1] = {2'b10, u[5:0]};
    end else if (u <= 21'hFFFF) begin
      b.cnt      = 3'd3;
      b.bytes[0] = {4'b1110, u[15:12]};
      b.bytes[1] = {2'b10, u[11:6]};
      b.bytes[2] = {2'b10, u[5:0]};
    end else begin
      b.cnt      = 3'd4;
      b.bytes[0] = {5'b11110, u[20:18]};
      b.bytes[1] = {2'b10, u[17:12]};
      b.bytes[2] = {2'b10, u[11:6]};
      b.bytes[3] = {2'b10, u[5:0]};
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/json_string_unescape.sv =====
// ============================================================================
// json_string_unescape - streaming decoder for one JSON string literal
// Takes JSON text a byte at a time and emits the decoded UTF-8 bytes.
// ============================================================================
//
// Input channel (in_*): one text byte per transaction, starting at the
// opening quote. Byte 0 marks end of text.
// Output channel (out_*): one result per transaction. Every input byte gives
// 1 to 4 results; out_tlast marks the last result of an input byte. A byte
// that decodes to nothing gives one result with out_tuser (has_byte) low.
// A closing quote ends the string with status ok, errors end it with an
// error status and the block is idle again, waiting for the next quote.
//
// The first result of a byte is valid in the cycle after its accept.
// The block takes one input byte per cycle while each byte gives one result
// and the receiver is ready; a byte that expands to a multi-byte UTF-8 sequence
// holds the input while the single output burst register drains it byte by byte.
// The next byte is taken in the cycle the last result of a burst leaves.
// Reset returns the decoder to idle and empties the burst register.
// A stalled receiver holds the current result; the input stalls with it.
//
module json_string_unescape
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] status, [11] finished
  output logic        out_tuser,  // [0] has_byte
  output logic        out_tlast
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_BODY   = 4'd1,
    PH_ESC    = 4'd2,
    PH_HEX1_0 = 4'd3,
    PH_HEX1_1 = 4'd4,
    PH_HEX1_2 = 4'd5,
    PH_HEX1_3 = 4'd6,
    PH_SBSL   = 4'd7,
    PH_SU     = 4'd8,
    PH_HEX2_0 = 4'd9,
    PH_HEX2_1 = 4'd10,
    PH_HEX2_2 = 4'd11,
    PH_HEX2_3 = 4'd12
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [15:0]     accum_r, accum_nxt;
  logic [9:0]      hsurr_r, hsurr_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [3:0][7:0] bytes_r, bytes_nxt;
  logic            has_r, has_nxt;
  logic [2:0]      status_r, status_nxt;
  logic            fin_r, fin_nxt;

  logic        in_acc, out_acc;
  logic [7:0]  c;
  logic        hex_ok;
  logic [3:0]  hex_v;
  logic [15:0] acc_new;
  logic [20:0] supp_cp;
  burst_t      enc;

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;
  assign c       = in_tdata;

  // Take a byte when the burst register is empty or empties this cycle
  assign in_tready = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_tready);

  // Decode one hex digit
  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_v = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_v = 4'(c - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_new = {accum_r[11:0], hex_v};
  assign supp_cp = {1'b0, hsurr_r, acc_new[9:0]} + SUPP_BASE;

  // Encode the first value, or the combined pair on the second value
  always_comb begin
    if (phase_r == PH_HEX2_3) begin
      enc = utf8_encode(supp_cp);
    end else begin
      enc = utf8_encode({5'd0, acc_new});
    end
  end

  // Next state and result burst for the accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    hsurr_nxt  = hsurr_r;
    bytes_nxt  = '0;
    has_nxt    = 1'b0;
    status_nxt = ST_RUN;
    fin_nxt    = 1'b0;
    cnt_nxt    = 3'd1;
    unique case (phase_r) inside
      PH_BODY: begin
        if (c == CH_QUOTE) begin
          status_nxt = ST_OK;
          fin_nxt    = 1'b1;
        end else if (c == CH_BSL) begin
          phase_nxt = PH_ESC;
        end else if (c == CH_NUL) begin
          status_nxt = ST_NOQ;
          fin_nxt    = 1'b1;
        end else if (c < CH_SPACE) begin
          status_nxt = ST_CTRL;
          fin_nxt    = 1'b1;
        end else begin
          bytes_nxt[0] = c;
          has_nxt      = 1'b1;
        end
      end
      PH_ESC: begin
        phase_nxt = PH_BODY;
        has_nxt   = 1'b1;
        unique case (c) inside
          CH_QUOTE, CH_BSL, CH_SLASH: bytes_nxt[0] = c;
          CH_B:    bytes_nxt[0] = 8'h08;
          CH_F:    bytes_nxt[0] = 8'h0C;
          CH_N:    bytes_nxt[0] = 8'h0A;
          CH_R:    bytes_nxt[0] = 8'h0D;
          CH_T:    bytes_nxt[0] = 8'h09;
          CH_U: begin
            phase_nxt = PH_HEX1_0;
            accum_nxt = '0;
            has_nxt   = 1'b0;
          end
          default: begin
            has_nxt    = 1'b0;
            status_nxt = ST_ESC;
            fin_nxt    = 1'b1;
          end
        endcase
      end
      PH_HEX1_0, PH_HEX1_1, PH_HEX1_2, PH_HEX2_0, PH_HEX2_1, PH_HEX2_2: begin
        if (!hex_ok) begin
          status_nxt = ST_HEX;
          fin_nxt    = 1'b1;
        end else begin
          accum_nxt = acc_new;
          phase_nxt = phase_t'(phase_r + 4'd1);
        end
      end
      PH_HEX1_3: begin
        if (!hex_ok) begin
          status_nxt = ST_HEX;
          fin_nxt    = 1'b1;
        end else begin
          accum_nxt = acc_new;
          if (acc_new >= HI_SURR_LO && acc_new <= HI_SURR_HI) begin
            hsurr_nxt = acc_new[9:0];
            phase_nxt = PH_SBSL;
          end else begin
            phase_nxt = PH_BODY;
            bytes_nxt = enc.bytes;
            cnt_nxt   = enc.cnt;
            has_nxt   = 1'b1;
          end
        end
      end
      PH_HEX2_3: begin
        if (!hex_ok) begin
          status_nxt = ST_HEX;
          fin_nxt    = 1'b1;
        end else begin
          accum_nxt = acc_new;
          if (acc_new < LO_SURR_LO || acc_new > LO_SURR_HI) begin
            status_nxt = ST_SURR;
            fin_nxt    = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
            bytes_nxt = enc.bytes;
            cnt_nxt   = enc.cnt;
            has_nxt   = 1'b1;
          end
        end
      end
      PH_SBSL: begin
        if (c == CH_BSL) begin
          phase_nxt = PH_SU;
        end else begin
          status_nxt = ST_SURR;
          fin_nxt    = 1'b1;
        end
      end
      PH_SU: begin
        if (c == CH_U) begin
          phase_nxt = PH_HEX2_0;
          accum_nxt = '0;
        end else begin
          status_nxt = ST_SURR;
          fin_nxt    = 1'b1;
        end
      end
      default: begin
        if (c == CH_QUOTE) begin
          phase_nxt = PH_BODY;
        end else begin
          status_nxt = ST_OPEN;
          fin_nxt    = 1'b1;
        end
      end
    endcase
    // Any end of string returns to idle
    if (fin_nxt) begin
      phase_nxt = PH_IDLE;
    end
  end

  // Hold decoder state; load or drain the result burst
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      accum_r <= '0;
      hsurr_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (in_acc) begin
        phase_r  <= phase_nxt;
        accum_r  <= accum_nxt;
        hsurr_r  <= hsurr_nxt;
        cnt_r    <= cnt_nxt;
        bytes_r  <= bytes_nxt;
        has_r    <= has_nxt;
        status_r <= status_nxt;
        fin_r    <= fin_nxt;
      end else if (out_acc) begin
        cnt_r   <= cnt_r - 3'd1;
        bytes_r <= {8'd0, bytes_r[3:1]};
      end
    end
  end

  // Drive the current result
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {4'd0, fin_r, status_r, bytes_r[0]};
  assign out_tuser  = has_r;
  assign out_tlast  = (cnt_r == 3'd1);

endmodule

// ===== sim/tb_json_string_unescape.sv =====
// ============================================================================
// tb_json_string_unescape - self-checking bench for the JSON string unescaper
// Feeds JSON text one byte per transaction: a short directed string set, then
// random strings that are mostly well formed with random content, ended by a
// closing quote or by an injected error. Idle-state noise is mixed in. A
// scoreboard predicts every result of each accepted byte and compares it
// field by field. Both channels idle and stall at random.
// ============================================================================
module tb_json_string_unescape
  import jsu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One decoded result as the block presents it
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic [2:0] status;
    logic       finished;
    logic       last;
  } decoded_t;

  // Where the decoder stands within a string
  typedef enum logic [2:0] {
    PH_IDLE, PH_BODY, PH_ESC, PH_HEX1, PH_LOW_BSL, PH_LOW_U, PH_HEX2
  } scan_phase_t;

  // Scoreboard: decoder prediction plus the queue of pending results
  class unescape_scoreboard;
    decoded_t    decoded_q[$];
    scan_phase_t phase;
    int          digit_cnt;
    logic [15:0] code_acc;
    logic [15:0] high_half;
    int          errors;

    function new();
      phase     = PH_IDLE;
      digit_cnt = 0;
      code_acc  = '0;
      high_half = '0;
      errors    = 0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void add(logic [7:0] data, logic has_byte, logic [2:0] status,
                      logic finished);
      decoded_t d;
      d.data     = data;
      d.has_byte = has_byte;
      d.status   = status;
      d.finished = finished;
      d.last     = 1'b0;
      decoded_q.insert(decoded_q.size(), d);
    endfunction

    function void add_empty();
      add(8'h00, 1'b0, ST_RUN, 1'b0);
    endfunction

    // End the string and fall back to idle
    function void close_string(logic [2:0] status);
      phase = PH_IDLE;
      add(8'h00, 1'b0, status, 1'b1);
    endfunction

    // Split a code point into its UTF-8 bytes, lead byte first
    function void add_utf8(logic [20:0] u);
      if (u <= 21'h7F) begin
        add(u[7:0], 1'b1, ST_RUN, 1'b0);
      end else if (u <= 21'h7FF) begin
        add({3'b110, u[10:6]}, 1'b1, ST_RUN, 1'b0);
        add({2'b10, u[5:0]}, 1'b1, ST_RUN, 1'b0);
      end else if (u <= 21'hFFFF) begin
        add({4'b1110, u[15:12]}, 1'b1, ST_RUN, 1'b0);
        add({2'b10, u[11:6]}, 1'b1, ST_RUN, 1'b0);
        add({2'b10, u[5:0]}, 1'b1, ST_RUN, 1'b0);
      end else begin
        add({5'b11110, u[20:18]}, 1'b1, ST_RUN, 1'b0);
        add({2'b10, u[17:12]}, 1'b1, ST_RUN, 1'b0);
        add({2'b10, u[11:6]}, 1'b1, ST_RUN, 1'b0);
        add({2'b10, u[5:0]}, 1'b1, ST_RUN, 1'b0);
      end
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
      return -1;
    endfunction

    // Advance the prediction by one accepted text byte
    function void note_input(logic [7:0] c);
      int          hv;
      logic [15:0] hi_off;
      logic [15:0] lo_off;
      case (phase) inside
        PH_BODY: begin
          if (c == CH_QUOTE) close_string(ST_OK);
          else if (c == CH_BSL) begin
            phase = PH_ESC;
            add_empty();
          end else if (c == CH_NUL) close_string(ST_NOQ);
          else if (c < CH_SPACE) close_string(ST_CTRL);
          else add(c, 1'b1, ST_RUN, 1'b0);
        end
        PH_ESC: begin
          phase = PH_BODY;
          case (c) inside
            CH_QUOTE, CH_BSL, CH_SLASH: add(c, 1'b1, ST_RUN, 1'b0);
            CH_B: add(8'h08, 1'b1, ST_RUN, 1'b0);
            CH_F: add(8'h0C, 1'b1, ST_RUN, 1'b0);
            CH_N: add(8'h0A, 1'b1, ST_RUN, 1'b0);
            CH_R: add(8'h0D, 1'b1, ST_RUN, 1'b0);
            CH_T: add(8'h09, 1'b1, ST_RUN, 1'b0);
            CH_U: begin
              phase     = PH_HEX1;
              digit_cnt = 0;
              code_acc  = '0;
              add_empty();
            end
            default: close_string(ST_ESC);
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          hv = hex_value(c);
          if (hv < 0) close_string(ST_HEX);
          else begin
            code_acc = {code_acc[11:0], hv[3:0]};
            if (digit_cnt < 3) begin
              digit_cnt++;
              add_empty();
            end else if (phase == PH_HEX1) begin
              // A high surrogate waits for its low half
              if (code_acc >= HI_SURR_LO && code_acc <= HI_SURR_HI) begin
                high_half = code_acc;
                phase     = PH_LOW_BSL;
                add_empty();
              end else begin
                phase = PH_BODY;
                add_utf8({5'd0, code_acc});
              end
            end else if (code_acc < LO_SURR_LO || code_acc > LO_SURR_HI) begin
              close_string(ST_SURR);
            end else begin
              hi_off = high_half - HI_SURR_LO;
              lo_off = code_acc - LO_SURR_LO;
              phase  = PH_BODY;
              add_utf8({1'b0, hi_off[9:0], lo_off[9:0]} + SUPP_BASE);
            end
          end
        end
        PH_LOW_BSL: begin
          if (c != CH_BSL) close_string(ST_SURR);
          else begin
            phase = PH_LOW_U;
            add_empty();
          end
        end
        PH_LOW_U: begin
          if (c != CH_U) close_string(ST_SURR);
          else begin
            phase     = PH_HEX2;
            digit_cnt = 0;
            code_acc  = '0;
            add_empty();
          end
        end
        default: begin
          if (c == CH_QUOTE) begin
            phase = PH_BODY;
            add_empty();
          end else close_string(ST_OPEN);
        end
      endcase
      decoded_q[decoded_q.size() - 1].last = 1'b1;
    endfunction

    // Compare one output transaction with the oldest pending result
    function void check_result(logic [15:0] tdata, logic tuser, logic tlast);
      decoded_t d;
      if (decoded_q.size() == 0) begin
        errors++;
        $error("result with nothing pending: tdata %h tuser %b tlast %b",
               tdata, tuser, tlast);
        return;
      end
      d = decoded_q.pop_front();
      if (tdata[7:0] !== d.data) begin
        errors++;
        $error("out_byte: expected %h, got %h", d.data, tdata[7:0]);
      end
      if (tuser !== d.has_byte) begin
        errors++;
        $error("has_byte: expected %b, got %b", d.has_byte, tuser);
      end
      if (tdata[10:8] !== d.status) begin
        errors++;
        $error("status: expected %0d, got %0d", d.status, tdata[10:8]);
      end
      if (tdata[11] !== d.finished) begin
        errors++;
        $error("finished: expected %b, got %b", d.finished, tdata[11]);
      end
      if (tlast !== d.last) begin
        errors++;
        $error("last: expected %b, got %b", d.last, tlast);
      end
    endfunction

    function void report_leftover();
      if (decoded_q.size() != 0) begin
        errors++;
        $error("%0d results never arrived", decoded_q.size());
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  unescape_scoreboard sb = new();
  logic [7:0]         text_q[$];
  int                 in_idle_pct  = 0;
  int                 out_idle_pct = 0;

  always #5ns clk = ~clk;

  json_string_unescape i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Stall the receiver at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Record each transaction on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // Append one byte to the text to send
  function automatic void text_add(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic bit is_escape(logic [7:0] c);
    case (c) inside
      CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Hex digit with random letter case
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    if ($urandom_range(3) == 0) return CH_NUL;
    do c = 8'($urandom_range(255)); while (is_hex(c));
    return c;
  endfunction

  function automatic void add_hex4(logic [15:0] v);
    text_add(hex_char(v[15:12]));
    text_add(hex_char(v[11:8]));
    text_add(hex_char(v[7:4]));
    text_add(hex_char(v[3:0]));
  endfunction

  function automatic void add_u(logic [15:0] v);
    text_add(CH_BSL);
    text_add(CH_U);
    add_hex4(v);
  endfunction

  // Append one well-formed piece of string content
  function automatic void add_piece();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(7)) inside
      0, 1: begin
        do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == CH_QUOTE || c == CH_BSL);
        text_add(c);
      end
      2: text_add(8'($urandom_range(8'h80, 8'hFF)));
      3: begin
        do c = 8'($urandom_range(255)); while (!is_escape(c) || c == CH_U);
        text_add(CH_BSL);
        text_add(c);
      end
      4: add_u(16'($urandom_range(16'h007F)));
      5: begin
        // two- and three-byte values, lone low surrogates included
        do v = 16'($urandom_range(16'h0080, 16'hFFFF));
        while (v >= HI_SURR_LO && v <= HI_SURR_HI);
        add_u(v);
      end
      6: begin
        add_u(16'($urandom_range(HI_SURR_LO, HI_SURR_HI)));
        add_u(16'($urandom_range(LO_SURR_LO, LO_SURR_HI)));
      end
      default: begin
        case ($urandom_range(9))
          0: add_u(16'h0000);
          1: add_u(16'h007F);
          2: add_u(16'h0080);
          3: add_u(16'h07FF);
          4: add_u(16'h0800);
          5: add_u(16'hFFFF);
          6: add_u(LO_SURR_LO);
          7: add_u(LO_SURR_HI);
          8: begin
            add_u(HI_SURR_LO);
            add_u(LO_SURR_LO);
          end
          default: begin
            add_u(HI_SURR_HI);
            add_u(LO_SURR_HI);
          end
        endcase
      end
    endcase
  endfunction

  // Append the closing quote or one of the ways a string can break
  function automatic void add_ending();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(11)) inside
      0, 1, 2, 3, 4, 5: text_add(CH_QUOTE);
      6: text_add(CH_NUL);
      7: text_add(8'($urandom_range(1, 31)));
      8: begin
        if ($urandom_range(3) == 0) c = CH_NUL;
        else do c = 8'($urandom_range(255)); while (is_escape(c));
        text_add(CH_BSL);
        text_add(c);
      end
      9: begin
        text_add(CH_BSL);
        text_add(CH_U);
        repeat ($urandom_range(3)) text_add(hex_char(4'($urandom_range(15))));
        text_add(non_hex_byte());
      end
      default: begin
        // high surrogate followed by a broken low half
        add_u(16'($urandom_range(HI_SURR_LO, HI_SURR_HI)));
        case ($urandom_range(3))
          0: begin
            if ($urandom_range(3) == 0) c = CH_NUL;
            else do c = 8'($urandom_range(255)); while (c == CH_BSL);
            text_add(c);
          end
          1: begin
            do c = 8'($urandom_range(255)); while (c == CH_U);
            text_add(CH_BSL);
            text_add(c);
          end
          2: begin
            case ($urandom_range(3))
              0: v = HI_SURR_HI;
              1: v = LO_SURR_HI + 16'd1;
              default: begin
                do v = 16'($urandom_range(16'hFFFF));
                while (v >= LO_SURR_LO && v <= LO_SURR_HI);
              end
            endcase
            add_u(v);
          end
          default: begin
            text_add(CH_BSL);
            text_add(CH_U);
            repeat ($urandom_range(3)) text_add(hex_char(4'($urandom_range(15))));
            text_add(non_hex_byte());
          end
        endcase
      end
    endcase
  endfunction

  // One string, sometimes preceded by stray bytes while idle
  function automatic void build_string();
    logic [7:0] c;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
        text_add(c);
      end
    end
    text_add(CH_QUOTE);
    repeat ($urandom_range(5)) add_piece();
    add_ending();
  endfunction

  // Drive one byte and hold it until the transaction completes
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i]);
    text_q.delete();
  endtask

  // Hold the input until every pending result has left
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int sent;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle noise, extreme bytes, a full surrogate pair, control, escape and hex errors
    text_q = '{CH_NUL, CH_QUOTE, 8'hFF, CH_BSL, CH_U, 8'h44, 8'h42, 8'h46, 8'h46,
               CH_BSL, CH_U, 8'h64, 8'h66, 8'h46, 8'h66, 8'h1F,
               CH_QUOTE, CH_BSL, 8'h78,
               CH_QUOTE, CH_BSL, CH_U, 8'h67,
               CH_QUOTE, CH_QUOTE};
    send_text();
    wait_drained();

    // Random strings under three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct  = 24;
          out_idle_pct = 48;
        end
        1: begin
          in_idle_pct  = 48;
          out_idle_pct = 24;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < 60) begin
        build_string();
        sent += text_q.size();
        send_text();
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    sb.report_leftover();
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
